### design/spi_bus_monitor_assert.svh
// ----------------------------------------------------------------------------
// spi_bus_monitor assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SPI_BUS_MONITOR_ASSERT_SVH
`define SPI_BUS_MONITOR_ASSERT_SVH

// same-cycle implication
`define SBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/spibm_pkg.sv
// ----------------------------------------------------------------------------
// spibm_pkg
// Types, constants and helpers shared by the SPI bus monitor modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spibm_pkg;

    // timestamp and field widths
    localparam int TS_BITS   = 48;
    localparam int OUT_TS_W  = 48;
    localparam int WORD_W    = 64;
    localparam int LEN_W     = 7;
    localparam int POS_W     = 6;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 7;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLOCK_IDLE_LEVEL    = 4'd0,
        CFG_SAMPLE_ON_TRAILING  = 4'd1,
        CFG_ENABLE_ACTIVE_LEVEL = 4'd2,
        CFG_ENABLE_PRESENT      = 4'd3,
        CFG_MOSI_PRESENT        = 4'd4,
        CFG_MISO_PRESENT        = 4'd5,
        CFG_LSB_FIRST           = 4'd6,
        CFG_BITS_PER_WORD       = 4'd7
    } t_cfg_idx;

    // monitor phase
    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_POLERR = 2'd1,
        PH_SHIFT  = 2'd2
    } t_phase;

    // event kinds
    typedef enum logic [1:0] {
        EV_WORD   = 2'd0,
        EV_START  = 2'd1,
        EV_END    = 2'd2,
        EV_POLERR = 2'd3
    } t_kind;

    typedef struct packed {
        logic             clock_idle_level;
        logic             sample_on_trailing;
        logic             enable_active_level;
        logic             enable_present;
        logic             mosi_present;
        logic             miso_present;
        logic             lsb_first;
        logic [LEN_W-1:0] bits_per_word;
    } t_cfg;

    typedef struct packed {
        t_kind               event_kind;
        logic [WORD_W-1:0]   mosi_data;
        logic [WORD_W-1:0]   miso_data;
        logic [OUT_TS_W-1:0] start_sample;
        logic [OUT_TS_W-1:0] end_sample;
        logic                last_of_run;
    } t_event;

    // word length clamped to 1..64
    function automatic logic [LEN_W-1:0] word_len(input logic [LEN_W-1:0] bpw);
        logic [LEN_W-1:0] len;
        if (bpw == '0) begin
            len = LEN_W'(1);
        end else if (bpw > LEN_W'(WORD_W)) begin
            len = LEN_W'(WORD_W);
        end else begin
            len = bpw;
        end
        return len;
    endfunction

endpackage

### design/spi_bus_monitor.sv
// ----------------------------------------------------------------------------
// spi_bus_monitor
// Passive SPI bus monitor: line samples in, word and transaction events out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample of the SPI lines per beat (clock, MOSI, MISO,
//   chip enable). Each beat advances the timestamp by one.
//   m_axis carries events: tuser is the kind (word, start, end, polarity
//   error), tdata the two words and the begin/end timestamps, tlast marks
//   the final event caused by one sample.
//   The cfg channel writes one register per beat; it is always ready and is
//   to be written only while no sample is being processed.
// Timing:
//   a sample's events are registered in the event queue, which feeds m_axis.
//   One sample is taken per cycle while the queue has room; a sample makes
//   zero, one or two events; a two-event sample drains at one event per cycle
//   while m_axis is ready, set by the four-entry queue's single output port.
// Reset and stall:
//   reset clears the phase, timestamp, queue and registers to their defaults.
//   When m_axis stalls, samples keep coming in until the queue has fewer than
//   two free entries, then s_axis_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spi_bus_monitor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // sample stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] clock_level, [1] mosi_level, [2] miso_level, [3] enable_level
    input  logic [7:0]                       s_axis_tdata,
    // event stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [63:0] mosi_data, [127:64] miso_data, [175:128] start_sample,
    // [223:176] end_sample
    output logic [223:0]                     m_axis_tdata,
    // [1:0] event_kind
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast,
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [spibm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spibm_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import spibm_pkg::*;

    t_cfg       r_cfg;
    logic       w_in_beat;
    logic       w_room;
    t_event     w_ev0, w_ev1, w_out_ev;
    logic [1:0] w_ev_count;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = w_room;
    assign w_in_beat     = s_axis_tvalid && w_room;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_idle_level    <= 1'b0;
            r_cfg.sample_on_trailing  <= 1'b0;
            r_cfg.enable_active_level <= 1'b0;
            r_cfg.enable_present      <= 1'b1;
            r_cfg.mosi_present        <= 1'b1;
            r_cfg.miso_present        <= 1'b1;
            r_cfg.lsb_first           <= 1'b0;
            r_cfg.bits_per_word       <= LEN_W'(8);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CLOCK_IDLE_LEVEL:    r_cfg.clock_idle_level    <= i_cfg_data[0];
                CFG_SAMPLE_ON_TRAILING:  r_cfg.sample_on_trailing  <= i_cfg_data[0];
                CFG_ENABLE_ACTIVE_LEVEL: r_cfg.enable_active_level <= i_cfg_data[0];
                CFG_ENABLE_PRESENT:      r_cfg.enable_present      <= i_cfg_data[0];
                CFG_MOSI_PRESENT:        r_cfg.mosi_present        <= i_cfg_data[0];
                CFG_MISO_PRESENT:        r_cfg.miso_present        <= i_cfg_data[0];
                CFG_LSB_FIRST:           r_cfg.lsb_first           <= i_cfg_data[0];
                CFG_BITS_PER_WORD:       r_cfg.bits_per_word       <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // sample processing
    spibm_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (w_in_beat),
        .i_clock_level  (s_axis_tdata[0]),
        .i_mosi_level   (s_axis_tdata[1]),
        .i_miso_level   (s_axis_tdata[2]),
        .i_enable_level (s_axis_tdata[3]),
        .o_ev0          (w_ev0),
        .o_ev1          (w_ev1),
        .o_ev_count     (w_ev_count)
    );

    // event queue
    spibm_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (w_ev_count),
        .i_ev0        (w_ev0),
        .i_ev1        (w_ev1),
        .i_pop        (m_axis_tready),
        .o_has_room   (w_room),
        .o_valid      (m_axis_tvalid),
        .o_ev         (w_out_ev)
    );

    // output beat packing
    assign m_axis_tdata = {w_out_ev.end_sample, w_out_ev.start_sample,
                           w_out_ev.miso_data, w_out_ev.mosi_data};
    assign m_axis_tuser = w_out_ev.event_kind;
    assign m_axis_tlast = w_out_ev.last_of_run;

endmodule

### design/spibm_core.sv
// ----------------------------------------------------------------------------
// spibm_core
// Edge detection, phase tracking and word assembly; one sample per beat,
// up to two events per sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spi_bus_monitor_assert.svh"

module spibm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spibm_pkg::t_cfg   i_cfg,
    input  logic              i_valid,
    input  logic              i_clock_level,
    input  logic              i_mosi_level,
    input  logic              i_miso_level,
    input  logic              i_enable_level,
    output spibm_pkg::t_event o_ev0,
    output spibm_pkg::t_event o_ev1,
    output logic [1:0]        o_ev_count
);
    import spibm_pkg::*;

    t_phase             r_phase, n_phase;
    logic [LEN_W-1:0]   r_bit_index, n_bit_index;
    logic               r_edge_trailing, n_edge_trailing;
    logic [WORD_W-1:0]  r_mosi_shift, n_mosi_shift;
    logic [WORD_W-1:0]  r_miso_shift, n_miso_shift;
    logic [TS_BITS-1:0] r_sample_count;
    logic [TS_BITS-1:0] r_word_start, n_word_start;
    logic [TS_BITS-1:0] r_event_start, n_event_start;
    logic               r_prev_clock, r_prev_enable, r_seen_first;

    logic [LEN_W-1:0]  w_len;
    logic              w_clk_edge, w_deact, w_fresh, w_clk_idle, w_enter;
    logic              w_add_ok;
    logic [POS_W-1:0]  w_pos;
    logic [WORD_W-1:0] w_onehot;
    logic [LEN_W-1:0]  w_bi_add;
    logic [WORD_W-1:0] w_mosi_add, w_miso_add;
    logic [OUT_TS_W-1:0] w_t;
    t_event            w_ev0, w_ev1;
    logic [1:0]        w_cnt;

    // line conditions for this sample
    assign w_len      = word_len(i_cfg.bits_per_word);
    assign w_clk_edge = r_seen_first && (i_clock_level != r_prev_clock);
    assign w_deact    = (i_enable_level != i_cfg.enable_active_level);
    assign w_fresh    = r_seen_first && (r_prev_enable != i_cfg.enable_active_level)
                        && !w_deact;
    assign w_clk_idle = (i_clock_level == i_cfg.clock_idle_level);
    assign w_t        = OUT_TS_W'(r_sample_count);

    // bit insertion, valid only below the word length
    assign w_add_ok = (r_bit_index < w_len);
    assign w_pos    = i_cfg.lsb_first ? r_bit_index[POS_W-1:0]
                                      : POS_W'(w_len - LEN_W'(1) - r_bit_index);
    assign w_onehot = WORD_W'(1) << w_pos;
    assign w_bi_add = w_add_ok ? r_bit_index + LEN_W'(1) : r_bit_index;
    assign w_mosi_add = (w_add_ok && i_cfg.mosi_present && i_mosi_level)
                        ? (r_mosi_shift | w_onehot) : r_mosi_shift;
    assign w_miso_add = (w_add_ok && i_cfg.miso_present && i_miso_level)
                        ? (r_miso_shift | w_onehot) : r_miso_shift;

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_WAIT: begin
                if (!i_cfg.enable_present) begin
                    if (w_clk_idle) n_phase = PH_SHIFT;
                end else if (w_fresh) begin
                    n_phase = w_clk_idle ? PH_SHIFT : PH_POLERR;
                end
            end
            PH_POLERR: begin
                if (!i_cfg.enable_present || w_deact) n_phase = PH_WAIT;
            end
            PH_SHIFT: begin
                if (i_cfg.enable_present && w_deact) n_phase = PH_WAIT;
            end
            default: n_phase = PH_WAIT;
        endcase
    end

    assign w_enter = (r_phase == PH_WAIT) && (n_phase == PH_SHIFT);

    // datapath and events
    always_comb begin
        n_bit_index     = r_bit_index;
        n_edge_trailing = r_edge_trailing;
        n_mosi_shift    = r_mosi_shift;
        n_miso_shift    = r_miso_shift;
        n_word_start    = r_word_start;
        n_event_start   = r_event_start;
        w_ev0           = '0;
        w_ev1           = '0;
        w_cnt           = 2'd0;
        case (r_phase)
            PH_WAIT: begin
                if (i_cfg.enable_present && w_fresh) begin
                    if (w_clk_idle) begin
                        w_ev0.event_kind   = EV_START;
                        w_ev0.start_sample = w_t;
                        w_ev0.end_sample   = w_t;
                        w_cnt              = 2'd1;
                    end else begin
                        n_event_start = r_sample_count;
                    end
                end
                if (w_enter) begin
                    n_bit_index     = '0;
                    n_edge_trailing = 1'b0;
                    n_mosi_shift    = '0;
                    n_miso_shift    = '0;
                end
            end
            PH_POLERR: begin
                if (i_cfg.enable_present && w_deact) begin
                    w_ev0.event_kind   = EV_POLERR;
                    w_ev0.start_sample = OUT_TS_W'(r_event_start);
                    w_ev0.end_sample   = w_t;
                    w_cnt              = 2'd1;
                end
            end
            PH_SHIFT: begin
                if (i_cfg.enable_present && w_deact) begin
                    // flush a word that only lacks its final trailing edge
                    if (!i_cfg.sample_on_trailing && (r_bit_index >= w_len)
                            && r_edge_trailing) begin
                        w_ev0.event_kind   = EV_WORD;
                        w_ev0.mosi_data    = r_mosi_shift;
                        w_ev0.miso_data    = r_miso_shift;
                        w_ev0.start_sample = OUT_TS_W'(r_word_start);
                        w_ev0.end_sample   = OUT_TS_W'(r_event_start);
                        w_ev1.event_kind   = EV_END;
                        w_ev1.start_sample = w_t;
                        w_ev1.end_sample   = w_t;
                        w_cnt              = 2'd2;
                    end else begin
                        w_ev0.event_kind   = EV_END;
                        w_ev0.start_sample = w_t;
                        w_ev0.end_sample   = w_t;
                        w_cnt              = 2'd1;
                    end
                end else if (w_clk_edge) begin
                    if (!r_edge_trailing) begin
                        // leading edge
                        if (r_bit_index == '0) n_word_start = r_sample_count;
                        if (!i_cfg.sample_on_trailing) begin
                            n_bit_index   = w_bi_add;
                            n_mosi_shift  = w_mosi_add;
                            n_miso_shift  = w_miso_add;
                            n_event_start = r_sample_count;
                        end
                        n_edge_trailing = 1'b1;
                    end else begin
                        // trailing edge
                        if (i_cfg.sample_on_trailing) begin
                            n_bit_index  = w_bi_add;
                            n_mosi_shift = w_mosi_add;
                            n_miso_shift = w_miso_add;
                        end
                        n_edge_trailing = 1'b0;
                        if (n_bit_index >= w_len) begin
                            w_ev0.event_kind   = EV_WORD;
                            w_ev0.mosi_data    = n_mosi_shift;
                            w_ev0.miso_data    = n_miso_shift;
                            w_ev0.start_sample = OUT_TS_W'(r_word_start);
                            w_ev0.end_sample   = w_t;
                            w_cnt              = 2'd1;
                            n_bit_index        = '0;
                            n_mosi_shift       = '0;
                            n_miso_shift       = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
        // mark the final event of this sample
        if (w_cnt == 2'd1) w_ev0.last_of_run = 1'b1;
        if (w_cnt == 2'd2) w_ev1.last_of_run = 1'b1;
    end

    assign o_ev0      = w_ev0;
    assign o_ev1      = w_ev1;
    assign o_ev_count = i_valid ? w_cnt : 2'd0;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_WAIT;
            r_bit_index     <= '0;
            r_edge_trailing <= 1'b0;
            r_mosi_shift    <= '0;
            r_miso_shift    <= '0;
            r_sample_count  <= '0;
            r_word_start    <= '0;
            r_event_start   <= '0;
            r_prev_clock    <= 1'b0;
            r_prev_enable   <= 1'b0;
            r_seen_first    <= 1'b0;
        end else if (i_valid) begin
            r_phase         <= n_phase;
            r_bit_index     <= n_bit_index;
            r_edge_trailing <= n_edge_trailing;
            r_mosi_shift    <= n_mosi_shift;
            r_miso_shift    <= n_miso_shift;
            r_sample_count  <= r_sample_count + TS_BITS'(1);
            r_word_start    <= n_word_start;
            r_event_start   <= n_event_start;
            r_prev_clock    <= i_clock_level;
            r_prev_enable   <= i_enable_level;
            r_seen_first    <= 1'b1;
        end
    end

    // checks
    `SBM_ASSERT_NOW(a_two_only_in_shift, o_ev_count == 2'd2, r_phase == PH_SHIFT, "two events outside shift phase")
    `SBM_ASSERT_NOW(a_bit_index_range, 1'b1, r_bit_index <= LEN_W'(WORD_W), "bit index past word width")
    `SBM_ASSERT_NEXT(a_deact_ends, i_valid && r_phase == PH_SHIFT && i_cfg.enable_present && w_deact, r_phase == PH_WAIT, "deactivation did not end transfer")

endmodule

### design/spibm_fifo.sv
// ----------------------------------------------------------------------------
// spibm_fifo
// Four-entry result queue: takes up to two events per beat, hands out one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spi_bus_monitor_assert.svh"

module spibm_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_count,
    input  spibm_pkg::t_event i_ev0,
    input  spibm_pkg::t_event i_ev1,
    input  logic              i_pop,
    output logic              o_has_room,
    output logic              o_valid,
    output spibm_pkg::t_event o_ev
);
    import spibm_pkg::*;

    t_event             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_CW-1:0] r_count, n_count;
    logic               w_pop;
    logic [FIFO_AW-1:0] w_wr_ptr1;

    assign w_pop      = i_pop && (r_count != '0);
    assign w_wr_ptr1  = r_wr_ptr + FIFO_AW'(1);
    assign o_valid    = (r_count != '0);
    assign o_has_room = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_ev       = r_mem[r_rd_ptr];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + FIFO_AW'(i_push_count);
        n_rd_ptr = w_pop ? r_rd_ptr + FIFO_AW'(1) : r_rd_ptr;
        n_count  = r_count + FIFO_CW'(i_push_count) - FIFO_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) r_mem[r_wr_ptr] <= i_ev0;
        if (i_push_count == 2'd2) r_mem[w_wr_ptr1] <= i_ev1;
    end

    // checks
    `SBM_ASSERT_NOW(a_count_bound, 1'b1, r_count <= FIFO_CW'(FIFO_DEPTH), "queue overfilled")
    `SBM_ASSERT_NOW(a_push_with_room, i_push_count != 2'd0, o_has_room, "push without room")
    `SBM_ASSERT_NEXT(a_pair_fill, i_push_count == 2'd2 && !w_pop, r_count == $past(r_count) + FIFO_CW'(2), "pair push miscounted")

endmodule
